FILE: hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial loopback echo filter.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int PATTERN_LENGTH = 60;
  localparam int MATCH_W = 6;

  localparam logic [8*PATTERN_LENGTH-1:0] PATTERN_TEXT =
    "This is a serialporttest for loopbackadapter! NOT Console!\n\r";

  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;

  typedef enum logic [1:0] {
    MODE_CROSSED  = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_LOOP     = 2'd2,
    MODE_FILTERED = 2'd3
  } mode_t;

  typedef enum logic {
    OP_TX = 1'b0,
    OP_RX = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       host_accept;
    logic       host_rx_valid;
    logic [7:0] host_rx_byte;
    logic       push;
    logic       pop;
  } cmd_t;

  function automatic logic [7:0] pattern_byte(logic [MATCH_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < PATTERN_LENGTH; i++) begin
      if (idx == MATCH_W'(i)) begin
        b = PATTERN_TEXT[(PATTERN_LENGTH-1-i)*8 +: 8];
      end
    end
    return b;
  endfunction

endpackage

FILE: hw/rtl/serial_loopback_echo_filter.sv
// ----------------------------------------------------------------------------
// serial_loopback_echo_filter
// Serial line adapter between a machine's UART and a host link, with a
// pattern-filtered loopback store.
//
//   channel  handshake              payload
//   input    start / busy           op, tx_byte, host_accept, host_rx_valid,
//                                   host_rx_byte
//   result   done (one-cycle)       to_host_valid, to_host_byte,
//                                   host_rx_taken, rx_byte, ok
//   config   cfg_valid / cfg_ready  cfg_data (mode)
//
// Each beat passes through the command queue and then the registered store
// read and result registers before its result appears.
// A new beat may be accepted every cycle; busy rises only if the queue fills.
// Reset clears the pointers, fill count, mode and match index; the store
// itself is not cleared.
// The receiver cannot stall, so the back end drains the queue every cycle.
// ----------------------------------------------------------------------------
module serial_loopback_echo_filter #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic [7:0] tx_byte,
  input  logic       host_accept,
  input  logic       host_rx_valid,
  input  logic [7:0] host_rx_byte,
  output logic       done,
  output logic       to_host_valid,
  output logic [7:0] to_host_byte,
  output logic       host_rx_taken,
  output logic [7:0] rx_byte,
  output logic       ok,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  sle_pkg::cmd_t front_cmd;
  sle_pkg::cmd_t head_cmd;
  logic          front_valid;
  logic          q_full;
  logic          q_empty;

  assign busy      = q_full;
  assign cfg_ready = q_empty;

  sle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .full          (q_full),
    .op            (op),
    .tx_byte       (tx_byte),
    .host_accept   (host_accept),
    .host_rx_valid (host_rx_valid),
    .host_rx_byte  (host_rx_byte),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .cmd_valid     (front_valid),
    .cmd           (front_cmd)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .push_cmd (front_cmd),
    .pop      (!q_empty),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  sle_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (!q_empty),
    .cmd           (head_cmd),
    .done          (done),
    .to_host_valid (to_host_valid),
    .to_host_byte  (to_host_byte),
    .host_rx_taken (host_rx_taken),
    .rx_byte       (rx_byte),
    .ok            (ok)
  );

endmodule

FILE: hw/rtl/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front
// Accepts beats, holds the mode register and the pattern matcher, and turns
// each beat into a command for the back end.
// ----------------------------------------------------------------------------
module sle_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  full,
  input  logic                  op,
  input  logic [7:0]            tx_byte,
  input  logic                  host_accept,
  input  logic                  host_rx_valid,
  input  logic [7:0]            host_rx_byte,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_data,
  output logic                  cmd_valid,
  output sle_pkg::cmd_t         cmd
);

  sle_pkg::mode_t                    mode;
  logic [sle_pkg::MATCH_W-1:0]       match_index;
  logic [sle_pkg::MATCH_W-1:0]       match_index_next;
  logic                              match_ok;
  logic                              is_tx;

  assign is_tx     = (sle_pkg::op_t'(op) == sle_pkg::OP_TX);
  assign cmd_valid = start && !full;

  always_comb begin
    match_ok         = 1'b0;
    match_index_next = '0;
    if (tx_byte == sle_pkg::CHAR_LT || tx_byte == sle_pkg::CHAR_GT) begin
      match_ok = 1'b1;
    end else if (tx_byte == sle_pkg::pattern_byte(match_index)) begin
      match_ok = 1'b1;
      if (match_index == sle_pkg::MATCH_W'(sle_pkg::PATTERN_LENGTH - 1)) begin
        match_index_next = '0;
      end else begin
        match_index_next = match_index + sle_pkg::MATCH_W'(1);
      end
    end else if (tx_byte == sle_pkg::pattern_byte('0)) begin
      match_ok         = 1'b1;
      match_index_next = sle_pkg::MATCH_W'(1);
    end
  end

  always_comb begin
    cmd.op            = sle_pkg::op_t'(op);
    cmd.tx_byte       = tx_byte;
    cmd.host_accept   = host_accept;
    cmd.host_rx_valid = host_rx_valid;
    cmd.host_rx_byte  = host_rx_byte;
    cmd.push          = 1'b0;
    cmd.pop           = 1'b0;
    unique case (mode)
      sle_pkg::MODE_LOOP: begin
        cmd.push = is_tx;
        cmd.pop  = !is_tx;
      end
      sle_pkg::MODE_FILTERED: begin
        cmd.push = is_tx && match_ok;
        cmd.pop  = !is_tx;
      end
      default: begin
        cmd.push = 1'b0;
        cmd.pop  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sle_pkg::MODE_CROSSED;
      match_index <= '0;
    end else if (cfg_write) begin
      mode        <= sle_pkg::mode_t'(cfg_data);
      match_index <= '0;
    end else if (cmd_valid && is_tx && mode == sle_pkg::MODE_FILTERED) begin
      match_index <= match_index_next;
    end
  end

endmodule

FILE: hw/rtl/sle_queue.sv
// ----------------------------------------------------------------------------
// sle_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sle_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output sle_pkg::cmd_t head
);

  sle_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back
// Executes commands against the loopback store and forms one result per beat.
// ----------------------------------------------------------------------------
module sle_back #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sle_pkg::cmd_t cmd,
  output logic          done,
  output logic          to_host_valid,
  output logic [7:0]    to_host_byte,
  output logic          host_rx_taken,
  output logic [7:0]    rx_byte,
  output logic          ok
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]    store [FIFO_DEPTH];
  logic [AW-1:0] write_pointer;
  logic [AW-1:0] read_pointer;
  logic [CW-1:0] fill_count;
  logic [7:0]    store_q;
  logic [7:0]    rx_hold;
  logic          use_store;
  logic          do_push;
  logic          do_pop;
  logic          is_rx;

  assign is_rx   = (cmd.op == sle_pkg::OP_RX);
  assign do_push = cmd_valid && cmd.push && (fill_count != CW'(FIFO_DEPTH));
  assign do_pop  = cmd_valid && cmd.pop && (fill_count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[write_pointer] <= cmd.tx_byte;
    end
    if (do_pop) begin
      store_q <= store[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_count    <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd_valid;
      if (do_push) begin
        write_pointer <= (write_pointer == AW'(FIFO_DEPTH - 1)) ? '0 : write_pointer + AW'(1);
        fill_count    <= fill_count + CW'(1);
      end
      if (do_pop) begin
        read_pointer <= (read_pointer == AW'(FIFO_DEPTH - 1)) ? '0 : read_pointer + AW'(1);
        fill_count   <= fill_count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      use_store     <= do_pop;
      to_host_valid <= !is_rx;
      to_host_byte  <= is_rx ? 8'h00 : cmd.tx_byte;
      host_rx_taken <= is_rx && !do_pop && cmd.host_rx_valid;
      rx_hold       <= (is_rx && !do_pop && cmd.host_rx_valid) ? cmd.host_rx_byte : 8'h00;
      ok            <= is_rx ? (do_pop || cmd.host_rx_valid) : cmd.host_accept;
    end
  end

  assign rx_byte = use_store ? store_q : rx_hold;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Serial loopback echo filter testbench
// Drives command beats from a backlog filled by the stimulus block and checks
// every one-cycle result against an in-bench model of the adapter. The model
// holds its own loopback store, pointers, match position and mode. Mode writes
// go through the configuration channel only while the adapter is idle. The
// stimulus covers all four modes, a full store, an empty store, the filter's
// pattern runs with wrap and restart, and varied sender gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LOOP_DEPTH = 256;
  localparam int TEXT_LEN = 60;
  localparam logic [8*TEXT_LEN-1:0] ECHO_TEXT =
    "This is a serialporttest for loopbackadapter! NOT Console!\n\r";

  typedef struct packed {
    sle_pkg::op_t op;
    logic [7:0]   tx_byte;
    logic         host_accept;
    logic         host_rx_valid;
    logic [7:0]   host_rx_byte;
  } uart_beat_t;

  typedef struct packed {
    logic       to_host_valid;
    logic [7:0] to_host_byte;
    logic       host_rx_taken;
    logic [7:0] rx_byte;
    logic       ok;
  } echo_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       op = 1'b0;
  logic [7:0] tx_byte = 8'h00;
  logic       host_accept = 1'b0;
  logic       host_rx_valid = 1'b0;
  logic [7:0] host_rx_byte = 8'h00;
  logic       done;
  logic       to_host_valid;
  logic [7:0] to_host_byte;
  logic       host_rx_taken;
  logic [7:0] rx_byte;
  logic       ok;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  uart_beat_t  beat_backlog[$];
  echo_reply_t replies_due[$];

  logic           beat_went = 1'b0;
  int             gap_pct = 0;
  sle_pkg::mode_t mode_req_val = sle_pkg::MODE_CROSSED;
  int             mode_req_count = 0;
  int             mode_ack_count = 0;

  sle_pkg::mode_t link_mode;
  logic [7:0]     loop_mem[LOOP_DEPTH];
  logic [7:0]     loop_wr;
  logic [7:0]     loop_rd;
  logic [8:0]     loop_fill;
  logic [5:0]     match_pos;

  int mismatch_count = 0;
  int beat_count = 0;
  int looped_count = 0;
  int dropped_count = 0;
  int refused_count = 0;
  int host_served_count = 0;

  serial_loopback_echo_filter #(.FIFO_DEPTH(LOOP_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .tx_byte(tx_byte),
    .host_accept(host_accept),
    .host_rx_valid(host_rx_valid),
    .host_rx_byte(host_rx_byte),
    .done(done),
    .to_host_valid(to_host_valid),
    .to_host_byte(to_host_byte),
    .host_rx_taken(host_rx_taken),
    .rx_byte(rx_byte),
    .ok(ok),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] text_byte(int i);
    return ECHO_TEXT[(TEXT_LEN-1-i)*8 +: 8];
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void loop_push(logic [7:0] b);
    if (loop_fill < 9'(LOOP_DEPTH)) begin
      loop_mem[loop_wr] = b;
      loop_wr = loop_wr + 8'd1;
      loop_fill = loop_fill + 9'd1;
      looped_count++;
    end else begin
      dropped_count++;
    end
  endfunction

  function automatic logic filter_takes(logic [7:0] b);
    if (b == sle_pkg::CHAR_LT || b == sle_pkg::CHAR_GT) begin
      match_pos = 6'd0;
      return 1'b1;
    end
    if (b == text_byte(int'(match_pos))) begin
      match_pos = (match_pos == 6'(TEXT_LEN - 1)) ? 6'd0 : match_pos + 6'd1;
      return 1'b1;
    end
    match_pos = 6'd0;
    if (b == text_byte(0)) begin
      match_pos = 6'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic echo_reply_t predict_reply(uart_beat_t b);
    echo_reply_t r;
    r = '0;
    if (b.op == sle_pkg::OP_TX) begin
      if (link_mode == sle_pkg::MODE_LOOP) begin
        loop_push(b.tx_byte);
      end else if (link_mode == sle_pkg::MODE_FILTERED) begin
        if (filter_takes(b.tx_byte)) begin
          loop_push(b.tx_byte);
        end else begin
          refused_count++;
        end
      end
      r.to_host_valid = 1'b1;
      r.to_host_byte = b.tx_byte;
      r.ok = b.host_accept;
    end else if ((link_mode == sle_pkg::MODE_LOOP || link_mode == sle_pkg::MODE_FILTERED) &&
                 loop_fill != 9'd0) begin
      r.rx_byte = loop_mem[loop_rd];
      loop_rd = loop_rd + 8'd1;
      loop_fill = loop_fill - 9'd1;
      r.ok = 1'b1;
    end else if (b.host_rx_valid) begin
      r.rx_byte = b.host_rx_byte;
      r.host_rx_taken = 1'b1;
      r.ok = 1'b1;
      host_served_count++;
    end
    return r;
  endfunction

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin : drive_beats
    uart_beat_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_went) begin
      if (beat_backlog.size() > 0 && $urandom_range(99) >= gap_pct) begin
        nxt = beat_backlog.pop_front();
        start <= 1'b1;
        op <= nxt.op;
        tx_byte <= nxt.tx_byte;
        host_accept <= nxt.host_accept;
        host_rx_valid <= nxt.host_rx_valid;
        host_rx_byte <= nxt.host_rx_byte;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      cfg_valid <= (mode_req_count != mode_ack_count);
      cfg_data <= mode_req_val;
    end
  end

  always @(posedge clk) begin : check_replies
    uart_beat_t  seen;
    echo_reply_t want;
    if (rst) begin
      beat_went <= 1'b0;
      link_mode = sle_pkg::MODE_CROSSED;
      loop_wr = 8'd0;
      loop_rd = 8'd0;
      loop_fill = 9'd0;
      match_pos = 6'd0;
    end else begin
      beat_went <= start && !busy;
      if (cfg_valid && cfg_ready) begin
        link_mode = sle_pkg::mode_t'(cfg_data);
        match_pos = 6'd0;
        mode_ack_count <= mode_ack_count + 1;
      end
      if (done) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("result strobe with nothing expected");
        end else begin
          want = replies_due.pop_front();
          if (to_host_valid !== want.to_host_valid)
            flag_mismatch($sformatf("to_host_valid %b, want %b",
                                    to_host_valid, want.to_host_valid));
          if (to_host_byte !== want.to_host_byte)
            flag_mismatch($sformatf("to_host_byte %h, want %h",
                                    to_host_byte, want.to_host_byte));
          if (host_rx_taken !== want.host_rx_taken)
            flag_mismatch($sformatf("host_rx_taken %b, want %b",
                                    host_rx_taken, want.host_rx_taken));
          if (rx_byte !== want.rx_byte)
            flag_mismatch($sformatf("rx_byte %h, want %h", rx_byte, want.rx_byte));
          if (ok !== want.ok)
            flag_mismatch($sformatf("ok %b, want %b", ok, want.ok));
        end
      end
      if (start && !busy) begin
        seen.op = sle_pkg::op_t'(op);
        seen.tx_byte = tx_byte;
        seen.host_accept = host_accept;
        seen.host_rx_valid = host_rx_valid;
        seen.host_rx_byte = host_rx_byte;
        replies_due.push_back(predict_reply(seen));
        beat_count++;
      end
    end
  end

  task automatic queue_beat(sle_pkg::op_t o, logic [7:0] txb, logic acc, logic hv,
                            logic [7:0] hb);
    uart_beat_t b;
    b.op = o;
    b.tx_byte = txb;
    b.host_accept = acc;
    b.host_rx_valid = hv;
    b.host_rx_byte = hb;
    beat_backlog.push_back(b);
  endtask

  task automatic queue_tx(logic [7:0] txb);
    queue_beat(sle_pkg::OP_TX, txb, 1'($urandom_range(1)), 1'($urandom_range(1)),
               8'($urandom_range(255)));
  endtask

  task automatic queue_rx();
    queue_beat(sle_pkg::OP_RX, 8'($urandom_range(255)), 1'($urandom_range(1)),
               $urandom_range(3) != 0, 8'($urandom_range(255)));
  endtask

  task automatic queue_mixed_traffic(int n, int tx_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < tx_pct) begin
        queue_tx(8'($urandom_range(255)));
      end else begin
        queue_rx();
      end
    end
  endtask

  // Mostly runs of the test string, usually from its start, some long enough to wrap,
  // with angle brackets, noise and occasional receives mixed in.
  task automatic queue_filter_traffic(int n);
    int made;
    int run;
    int pos;
    int pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        pos = ($urandom_range(3) == 0) ? int'($urandom_range(TEXT_LEN - 1)) : 0;
        run = ($urandom_range(4) == 0) ? 60 + int'($urandom_range(70))
                                       : 1 + int'($urandom_range(20));
        for (int i = 0; i < run && made < n; i++) begin
          if ($urandom_range(99) < 15) begin
            queue_rx();
          end else begin
            queue_tx(text_byte(pos));
            pos = (pos + 1) % TEXT_LEN;
          end
          made++;
        end
      end else if (pick < 75) begin
        queue_tx(($urandom_range(1) != 0) ? sle_pkg::CHAR_LT : sle_pkg::CHAR_GT);
        made++;
      end else begin
        queue_tx(8'($urandom_range(255)));
        made++;
      end
    end
  endtask

  task automatic settle();
    while (beat_backlog.size() != 0 || start || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(sle_pkg::mode_t m);
    settle();
    mode_req_val = m;
    mode_req_count++;
    while (mode_req_count != mode_ack_count) begin
      @(posedge clk);
    end
  endtask

  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_pct = 34;
    write_mode(sle_pkg::MODE_CROSSED);
    queue_beat(sle_pkg::OP_TX, 8'h00, 1'b0, 1'b1, 8'hFF);
    queue_beat(sle_pkg::OP_TX, 8'hFF, 1'b1, 1'b0, 8'h00);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b1, 8'hFF);
    queue_beat(sle_pkg::OP_RX, 8'hFF, 1'b1, 1'b0, 8'hA5);
    queue_beat(sle_pkg::OP_RX, 8'h5A, 1'b0, 1'b1, 8'h00);

    write_mode(sle_pkg::MODE_LOOP);
    queue_beat(sle_pkg::OP_TX, 8'h11, 1'b1, 1'b0, 8'h00);
    queue_beat(sle_pkg::OP_TX, 8'hEE, 1'b0, 1'b1, 8'h33);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b1, 8'h44);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b1, 1'b0, 8'h00);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b1, 8'h5A);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b0, 8'hC3);

    write_mode(sle_pkg::MODE_FILTERED);
    queue_tx(sle_pkg::CHAR_LT);
    queue_tx(sle_pkg::CHAR_GT);
    queue_tx("T");
    queue_tx("h");
    queue_tx("x");
    queue_tx("T");
    queue_tx("T");
    queue_tx("h");
    // Rewriting the mode mid-match must send the matcher back to the start.
    write_mode(sle_pkg::MODE_FILTERED);
    queue_tx("i");
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b0, 8'h00);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b0, 8'h00);
    queue_beat(sle_pkg::OP_RX, 8'h00, 1'b0, 1'b0, 8'h00);

    write_mode(sle_pkg::MODE_LOOP);
    gap_pct = 0;
    queue_mixed_traffic(270, 100);

    write_mode(sle_pkg::MODE_FILTERED);
    gap_pct = 59;
    queue_filter_traffic(120);

    write_mode(sle_pkg::MODE_LOOP);
    gap_pct = 34;
    queue_mixed_traffic(260, 0);
    queue_mixed_traffic(60, 50);

    write_mode(sle_pkg::MODE_CROSSED);
    gap_pct = 59;
    queue_mixed_traffic(50, 50);

    write_mode(sle_pkg::MODE_STRAIGHT);
    gap_pct = 34;
    queue_mixed_traffic(40, 50);

    write_mode(sle_pkg::MODE_FILTERED);
    gap_pct = 0;
    queue_filter_traffic(80);

    while (beat_backlog.size() != 0 || start) begin
      @(posedge clk);
    end
    waited = 0;
    while (replies_due.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", replies_due.size()));
    end

    $display("Ran %0d beats through all four modes with sender gaps of 0, 34 and 59 in 100.",
             beat_count);
    $display("Looped back %0d bytes, dropped %0d on a full store,",
             looped_count, dropped_count);
    $display("filter refused %0d, host served %0d.", refused_count, host_served_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_front.sv
hw/rtl/sle_queue.sv
hw/rtl/sle_back.sv
hw/rtl/serial_loopback_echo_filter.sv
tb/testbench.sv
